// ===== sv/qgi_pkg.sv =====
// Shared types, constants and helper functions for the quaternion gyro integrator.
// No dependencies; the top, the CORDIC and the lane import this package.
`default_nettype none

package qgi_pkg;

  localparam int FRAC_BITS_DEF    = 30;
  localparam int CORDIC_ITERS_DEF = 24;

  localparam logic [23:0] SAMPLE_PERIOD_RST = 24'd16777;
  localparam logic [32:0] HALF_PI_Q32       = 33'd6746518852;
  localparam logic [31:0] CORDIC_GAIN_Q32   = 32'd2608131496;

  typedef struct packed {
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] att_w;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic signed [31:0] att_z;
    logic               degenerate;
  } out_beat_t;

  typedef struct packed {
    logic               mul_en;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic               acc_clr;
    logic               acc_en;
    logic               acc_neg;
    logic               div_start;
    logic [63:0]        div_num;
    logic               div_neg;
    logic [31:0]        div_den;
    logic [5:0]         div_bits;
  } lane_ctrl_t;

  typedef struct packed {
    logic signed [63:0] prod;
    logic signed [65:0] acc;
    logic               div_busy;
    logic signed [32:0] quot;
  } lane_stat_t;

  typedef struct packed {
    logic [1:0] qi;
    logic [1:0] di;
    logic       neg;
  } term_t;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Arc tangent of 2^-i in Q.32, exact powers of two past the table.
  function automatic logic signed [39:0] atan_step(input logic [5:0] i);
    case (i)
      6'd0:    return 40'sd3373259426;
      6'd1:    return 40'sd1991351318;
      6'd2:    return 40'sd1052175346;
      6'd3:    return 40'sd534100635;
      6'd4:    return 40'sd268086748;
      6'd5:    return 40'sd134174063;
      6'd6:    return 40'sd67103403;
      6'd7:    return 40'sd33553749;
      6'd8:    return 40'sd16777131;
      6'd9:    return 40'sd8388597;
      6'd10:   return 40'sd4194303;
      6'd11:   return 40'sd2097152;
      default: return 40'sd1 <<< (6'd32 - i);
    endcase
  endfunction

  // Hamilton product terms: lane, step -> attitude index, delta index, sign.
  function automatic term_t prod_term(input logic [1:0] lane, input logic [1:0] k);
    case ({lane, k})
      4'b00_00: return '{2'd0, 2'd0, 1'b0};
      4'b00_01: return '{2'd1, 2'd1, 1'b1};
      4'b00_10: return '{2'd2, 2'd2, 1'b1};
      4'b00_11: return '{2'd3, 2'd3, 1'b1};
      4'b01_00: return '{2'd0, 2'd1, 1'b0};
      4'b01_01: return '{2'd1, 2'd0, 1'b0};
      4'b01_10: return '{2'd2, 2'd3, 1'b0};
      4'b01_11: return '{2'd3, 2'd2, 1'b1};
      4'b10_00: return '{2'd0, 2'd2, 1'b0};
      4'b10_01: return '{2'd2, 2'd0, 1'b0};
      4'b10_10: return '{2'd3, 2'd1, 1'b0};
      4'b10_11: return '{2'd1, 2'd3, 1'b1};
      4'b11_00: return '{2'd0, 2'd3, 1'b0};
      4'b11_01: return '{2'd3, 2'd0, 1'b0};
      4'b11_10: return '{2'd1, 2'd2, 1'b0};
      4'b11_11: return '{2'd2, 2'd1, 1'b1};
      default:  return '{2'd0, 2'd0, 1'b0};
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== sv/quaternion_gyro_integrator_top.sv =====
// Quaternion gyro integrator: one gyro beat in, one normalized attitude beat out.
// Its run time per beat is set by three passes through the shared 32-step square root,
// the CORDIC and the bit-serial lane dividers; a zero angle skips the CORDIC and the
// delta divide. One beat is in work at a time, so a new beat is taken only once the
// last result has been loaded into the output register.
// Synchronous reset sets the attitude to identity and the sample period to 16777.
`default_nettype none

module quaternion_gyro_integrator_top
  import qgi_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_beat_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_beat_t        out_data
);

  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_NMUL   = 5'd1;
  localparam logic [4:0] S_NSUM   = 5'd2;
  localparam logic [4:0] S_NSQRT  = 5'd3;
  localparam logic [4:0] S_NDIV   = 5'd4;
  localparam logic [4:0] S_WMUL   = 5'd5;
  localparam logic [4:0] S_WSUM   = 5'd6;
  localparam logic [4:0] S_WSQRT  = 5'd7;
  localparam logic [4:0] S_THETA  = 5'd8;
  localparam logic [4:0] S_CORD   = 5'd9;
  localparam logic [4:0] S_DMUL   = 5'd10;
  localparam logic [4:0] S_DDIV   = 5'd11;
  localparam logic [4:0] S_DDWAIT = 5'd12;
  localparam logic [4:0] S_PROD   = 5'd13;
  localparam logic [4:0] S_PACC   = 5'd14;
  localparam logic [4:0] S_PFIN   = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  logic [4:0]         state;
  logic [23:0]        sample_period;
  logic signed [31:0] att [4];
  logic signed [31:0] val [4];
  logic signed [31:0] dq  [4];
  logic signed [15:0] w   [3];
  logic signed [31:0] sh;
  logic [15:0]        mag_w;
  logic [1:0]         kcnt;
  logic               phase;
  logic               deg;

  lane_ctrl_t ctrl [4];
  lane_stat_t stat [4];

  logic        sq_start;
  logic [63:0] sq_value;
  logic        sq_busy;
  logic [31:0] sq_root;

  logic               cord_start;
  logic               cord_busy;
  logic signed [39:0] cord_cos;
  logic signed [39:0] cord_sin;

  logic [64:0] sum_sq;
  logic [39:0] theta;
  logic        res_load;
  logic [4:0]  norm_next;

  assign in_ready  = (state == S_IDLE);
  assign theta     = mag_w * sample_period;
  assign norm_next = phase ? S_DONE : S_WMUL;
  assign res_load  = (state == S_DONE) && (!out_valid || out_ready);

  assign sum_sq = {2'b0, stat[0].prod[62:0]} + {2'b0, stat[1].prod[62:0]}
                + {2'b0, stat[2].prod[62:0]} + {2'b0, stat[3].prod[62:0]};
  assign sq_value = sum_sq[64] ? '1 : sum_sq[63:0];
  assign sq_start = (state == S_NSUM) || (state == S_WSUM);

  assign cord_start = (state == S_THETA) && (theta != '0);

  qgi_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_value),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  qgi_cordic #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_ITERS (CORDIC_ITERS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .angle   (theta[39:3]),
    .busy    (cord_busy),
    .cos_out (cord_cos),
    .sin_out (cord_sin)
  );

  for (genvar g = 0; g < 4; g++) begin : g_lane
    qgi_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl[g]),
      .stat (stat[g])
    );
  end

  always_comb begin
    logic [31:0] vmag;
    logic [63:0] pmag;
    term_t       t_cur;
    term_t       t_prev;
    for (int i = 0; i < 4; i++) begin
      vmag   = val[i][31] ? 32'(-val[i]) : 32'(val[i]);
      pmag   = stat[i].prod[63] ? 64'(-stat[i].prod) : 64'(stat[i].prod);
      t_cur  = prod_term(2'(i), kcnt);
      t_prev = prod_term(2'(i), kcnt - 2'd1);
      ctrl[i] = '0;
      case (state)
        S_NMUL: begin
          ctrl[i].mul_en = 1'b1;
          ctrl[i].mul_a  = val[i];
          ctrl[i].mul_b  = val[i];
        end
        S_NSQRT: begin
          ctrl[i].div_start = !sq_busy && (sq_root != '0);
          ctrl[i].div_num   = {32'd0, vmag} << FRAC_BITS;
          ctrl[i].div_neg   = val[i][31];
          ctrl[i].div_den   = sq_root;
          ctrl[i].div_bits  = 6'(FRAC_BITS + 1);
        end
        S_WMUL: begin
          ctrl[i].mul_en = 1'b1;
          if (i < 3) begin
            ctrl[i].mul_a = 32'(w[i]);
            ctrl[i].mul_b = 32'(w[i]);
          end
        end
        S_DMUL: begin
          ctrl[i].mul_en = 1'b1;
          if (i < 3) begin
            ctrl[i].mul_a = 32'(w[i]);
            ctrl[i].mul_b = sh;
          end
        end
        S_DDIV: begin
          if (i < 3) begin
            ctrl[i].div_start = 1'b1;
            ctrl[i].div_num   = pmag;
            ctrl[i].div_neg   = stat[i].prod[63];
            ctrl[i].div_den   = {16'd0, mag_w};
            ctrl[i].div_bits  = 6'd32;
          end
        end
        S_PROD: begin
          ctrl[i].mul_en  = 1'b1;
          ctrl[i].mul_a   = val[t_cur.qi];
          ctrl[i].mul_b   = dq[t_cur.di];
          ctrl[i].acc_clr = (kcnt == 2'd0);
          ctrl[i].acc_en  = (kcnt != 2'd0);
          ctrl[i].acc_neg = t_prev.neg;
        end
        S_PACC: begin
          ctrl[i].acc_en  = 1'b1;
          ctrl[i].acc_neg = t_prev.neg;
        end
        default: begin
          ctrl[i] = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      sample_period <= SAMPLE_PERIOD_RST;
      att[0]        <= ONE;
      att[1]        <= '0;
      att[2]        <= '0;
      att[3]        <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sample_period <= cfg_wr_data;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            w[0]  <= in_data.rate_x;
            w[1]  <= in_data.rate_y;
            w[2]  <= in_data.rate_z;
            for (int i = 0; i < 4; i++) begin
              val[i] <= att[i];
            end
            deg   <= 1'b0;
            phase <= 1'b0;
            state <= S_NMUL;
          end
        end
        S_NMUL: begin
          state <= S_NSUM;
        end
        S_NSUM: begin
          state <= S_NSQRT;
        end
        S_NSQRT: begin
          if (!sq_busy) begin
            if (sq_root == '0) begin
              val[0] <= ONE;
              val[1] <= '0;
              val[2] <= '0;
              val[3] <= '0;
              deg    <= 1'b1;
              state  <= norm_next;
            end else begin
              state <= S_NDIV;
            end
          end
        end
        S_NDIV: begin
          if (!stat[0].div_busy) begin
            for (int i = 0; i < 4; i++) begin
              val[i] <= clamp32(66'(stat[i].quot));
            end
            state <= norm_next;
          end
        end
        S_WMUL: begin
          state <= S_WSUM;
        end
        S_WSUM: begin
          state <= S_WSQRT;
        end
        S_WSQRT: begin
          if (!sq_busy) begin
            mag_w <= sq_root[15:0];
            state <= S_THETA;
          end
        end
        S_THETA: begin
          if (theta == '0) begin
            dq[0] <= ONE;
            dq[1] <= '0;
            dq[2] <= '0;
            dq[3] <= '0;
            kcnt  <= 2'd0;
            state <= S_PROD;
          end else begin
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (!cord_busy) begin
            dq[0] <= clamp32({{26{cord_cos[39]}}, cord_cos});
            sh    <= clamp32({{26{cord_sin[39]}}, cord_sin});
            state <= S_DMUL;
          end
        end
        S_DMUL: begin
          state <= S_DDIV;
        end
        S_DDIV: begin
          state <= S_DDWAIT;
        end
        S_DDWAIT: begin
          if (!stat[0].div_busy) begin
            for (int i = 0; i < 3; i++) begin
              dq[i + 1] <= clamp32(66'(stat[i].quot));
            end
            kcnt  <= 2'd0;
            state <= S_PROD;
          end
        end
        S_PROD: begin
          kcnt <= kcnt + 2'd1;
          if (kcnt == 2'd3) begin
            state <= S_PACC;
          end
        end
        S_PACC: begin
          state <= S_PFIN;
        end
        S_PFIN: begin
          for (int i = 0; i < 4; i++) begin
            val[i] <= clamp32(stat[i].acc >>> FRAC_BITS);
          end
          phase <= 1'b1;
          state <= S_NMUL;
        end
        S_DONE: begin
          if (res_load) begin
            for (int i = 0; i < 4; i++) begin
              att[i] <= val[i];
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data.att_w      <= val[0];
      out_data.att_x      <= val[1];
      out_data.att_y      <= val[2];
      out_data.att_z      <= val[3];
      out_data.degenerate <= deg;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !res_load |=> $stable(att[0]) && $stable(att[1]) && $stable(att[2]) && $stable(att[3]))
    else $error("attitude changed without a result beat");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && out_valid && !out_ready |=> (state == S_DONE))
    else $error("result overwrote a beat still waiting at the output");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.att_w <= ONE) && (out_data.att_w >= -ONE)
              && (out_data.att_x <= ONE) && (out_data.att_x >= -ONE)
              && (out_data.att_y <= ONE) && (out_data.att_y >= -ONE)
              && (out_data.att_z <= ONE) && (out_data.att_z >= -ONE))
    else $error("normalized attitude component out of range");

endmodule

`default_nettype wire

// ===== sv/qgi_sqrt.sv =====
// Bit-serial 64-bit integer square root, two radicand bits per cycle.
// Depends on nothing beyond the clock and reset.
`default_nettype none

module qgi_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] value,
  output logic             busy,
  output logic [31:0]      root
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= value;
      res  <= '0;
      bitv <= 64'd1 << 62;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv == 64'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/qgi_cordic.sv =====
// Rotation-mode CORDIC for the sine and cosine of the half angle, with quadrant reduction.
// Depends on qgi_pkg for the CORDIC gain, half pi and the arc tangent steps.
`default_nettype none

module qgi_cordic
  import qgi_pkg::*;
#(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_ITERS = CORDIC_ITERS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [36:0]        angle,
  output logic                    busy,
  output logic signed [39:0]      cos_out,
  output logic signed [39:0]      sin_out
);

  localparam int ITERS = (CORDIC_ITERS > 32) ? 32 : CORDIC_ITERS;
  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RED  = 2'd1;
  localparam logic [1:0] C_ROT  = 2'd2;

  logic [1:0]         state;
  logic [5:0]         cnt;
  logic [1:0]         quad;
  logic signed [39:0] x;
  logic signed [39:0] y;
  logic signed [39:0] z;
  logic signed [39:0] hp_sh;
  logic signed [39:0] dx;
  logic signed [39:0] dy;
  logic signed [39:0] step;
  logic signed [39:0] c;
  logic signed [39:0] s;

  assign busy  = (state != C_IDLE);
  assign hp_sh = $signed({7'd0, HALF_PI_Q32}) <<< cnt;
  assign dx    = y >>> cnt;
  assign dy    = x >>> cnt;
  assign step  = atan_step(cnt);
  assign c     = x >>> (32 - FRAC_BITS);
  assign s     = y >>> (32 - FRAC_BITS);

  always_comb begin
    case (quad)
      2'd0: begin
        cos_out = c;
        sin_out = s;
      end
      2'd1: begin
        cos_out = -s;
        sin_out = c;
      end
      2'd2: begin
        cos_out = -c;
        sin_out = -s;
      end
      default: begin
        cos_out = s;
        sin_out = -c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      case (state)
        C_IDLE: begin
          if (start) begin
            state <= C_RED;
            cnt   <= 6'd4;
            quad  <= 2'd0;
            z     <= $signed({3'd0, angle});
            x     <= $signed({8'd0, CORDIC_GAIN_Q32});
            y     <= '0;
          end
        end
        C_RED: begin
          if (z >= hp_sh) begin
            z <= z - hp_sh;
            if (cnt < 6'd2) begin
              quad[cnt[0]] <= 1'b1;
            end
          end
          if (cnt == 6'd0) begin
            state <= C_ROT;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        C_ROT: begin
          if (z >= 0) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - step;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + step;
          end
          if (cnt == 6'(ITERS - 1)) begin
            state <= C_IDLE;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/qgi_lane.sv =====
// One arithmetic lane: registered 32x32 multiplier, signed accumulator and a
// restoring divider that yields one quotient bit per cycle. Depends on qgi_pkg.
`default_nettype none

module qgi_lane
  import qgi_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire lane_ctrl_t ctrl,
  output lane_stat_t      stat
);

  logic signed [63:0] prod;
  logic signed [65:0] acc;
  logic               busy;
  logic [31:0]        rem;
  logic [63:0]        low;
  logic [31:0]        quo;
  logic [31:0]        den;
  logic [5:0]         cnt;
  logic               neg;
  logic [32:0]        trial;
  logic               ge;
  logic [63:0]        num_hi;
  logic signed [65:0] prod_ext;

  assign trial    = {rem, low[63]};
  assign ge       = trial >= {1'b0, den};
  assign num_hi   = ctrl.div_num >> ctrl.div_bits;
  assign prod_ext = {{2{prod[63]}}, prod};

  assign stat.prod     = prod;
  assign stat.acc      = acc;
  assign stat.div_busy = busy;
  assign stat.quot     = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= ctrl.mul_a * ctrl.mul_b;
    end
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= ctrl.acc_neg ? acc - prod_ext : acc + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctrl.div_start) begin
      busy <= 1'b1;
      rem  <= num_hi[31:0];
      low  <= ctrl.div_num << (7'd64 - {1'b0, ctrl.div_bits});
      quo  <= '0;
      den  <= ctrl.div_den;
      cnt  <= ctrl.div_bits;
      neg  <= ctrl.div_neg;
    end else if (busy) begin
      rem <= ge ? 32'(trial - {1'b0, den}) : trial[31:0];
      quo <= {quo[30:0], ge};
      low <= low << 1;
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
